FILE: rtl/core/ssd_pkg.sv
// shared types and constants for the stereo ssd block matcher
package ssd_pkg;

    localparam int PIX_W  = 24;
    localparam int CH_W   = 8;
    localparam int COST_W = 26;
    localparam int DISP_W = 6;
    localparam int CMD_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_MATCH = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } ssd_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS   = 3'd0,
        CFG_MAX_DISP = 3'd1,
        CFG_WIDTH    = 3'd2,
        CFG_HEIGHT   = 3'd3,
        CFG_CHANNELS = 3'd4
    } ssd_cfg_idx_t;

    typedef struct packed {
        logic shift;
        logic acc_en;
        logic clear;
        logic scan;
    } ssd_cell_ctl_t;

endpackage

FILE: rtl/core/stereo_ssd_block_match.sv
// top level of the stereo ssd block matcher: pixel stores, sequencer, cell chain
//
// Input channel s_*: command 0 loads one left/right pixel pair, 1 requests a
// match at (column, row), 2 clears the running maximum disparity. Loads and
// clears give no beat on m_*. A match gives one beat on m_*: disparity, best
// cost and the running maximum after this match.
// Configuration writes (cfg_*) are taken at any time and must only change
// while no match is in flight.
// A match streams one window row at a time through a chain of MAX_SEARCH+1
// cells, one per candidate, then passes the flush state, shifts the costs
// out of the chain to the comparator in the scan state and registers the
// result in the done state; the single read port of each pixel store sets
// the streaming rate.
// The block takes no new input beat while a match runs. A finished result
// waits in the output register while the receiver stalls; loads and clears
// are still taken then. Reset (aresetn low, synchronous) restores the config
// defaults and clears the running maximum; pixel stores are not cleared.
module stereo_ssd_block_match
    import ssd_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_RADIUS = 7,
    parameter int MAX_SEARCH = 63
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_command,
    input  logic [5:0]            s_column,
    input  logic [5:0]            s_row,
    input  logic [7:0]            s_left_ch0,
    input  logic [7:0]            s_left_ch1,
    input  logic [7:0]            s_left_ch2,
    input  logic [7:0]            s_right_ch0,
    input  logic [7:0]            s_right_ch1,
    input  logic [7:0]            s_right_ch2,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [5:0]            m_disparity,
    output logic [25:0]           m_best_cost,
    output logic [5:0]            m_largest_disparity,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NC    = MAX_SEARCH + 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RDW   = $clog2(MAX_RADIUS + 1) > 0 ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int JW    = $clog2(2 * MAX_RADIUS + 2);
    localparam int EW    = $clog2(NC + 2 * MAX_RADIUS + 1);
    localparam int KW    = $clog2(NC + 1);
    localparam int SW    = $clog2(MAX_WIDTH + MAX_HEIGHT + MAX_SEARCH + 4 * MAX_RADIUS + 4) + 2;
    localparam int ACC_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 3 * 65025 + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROW   = 5'b00010,
        ST_FLUSH = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0] radius_reg;
    logic [5:0] max_disp_reg;
    logic [6:0] width_reg;
    logic [6:0] height_reg;
    logic [1:0] channels_reg;

    logic [PIX_W-1:0] left_mem  [DEPTH];
    logic [PIX_W-1:0] right_mem [DEPTH];
    logic [PIX_W-1:0] left_rd_reg, right_rd_reg;
    logic             rvalid_reg, racc_reg;

    logic [WW-1:0]  w_reg;
    logic [HW-1:0]  h_reg;
    logic [XW-1:0]  x_reg, d0_reg;
    logic [YW-1:0]  y_reg;
    logic [RDW-1:0] r_reg;
    logic [1:0]     nch_reg;
    logic [KW-1:0]  last_k_reg;
    logic [EW-1:0]  e_reg;
    logic [JW-1:0]  j_reg;
    logic [KW-1:0]  k_reg;
    logic [ACC_W-1:0] best_reg;
    logic [KW-1:0]    bestk_reg;
    logic [KW-1:0]    runmax_reg;
    logic             m_valid_reg;
    logic [5:0]       m_disp_reg, m_runmax_reg;
    logic [25:0]      m_cost_reg;

    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [RDW-1:0] r_eff;
    logic [KW-1:0]  dm_eff;
    logic [XW-1:0]  x_eff, d0_eff;
    logic [YW-1:0]  y_eff;
    logic [1:0]     nch_eff;

    logic s_fire, load_fire, match_fire, clear_fire;
    logic issue, row_last, out_fire;
    logic [EW-1:0] e_last;
    logic signed [SW-1:0] rcol_s, lcol_s, yy_s;
    logic [XW-1:0] rcol, lcol;
    logic [YW-1:0] yy;
    logic [AW-1:0] raddr, laddr, waddr;
    logic [KW-1:0] disp_k, runmax_new;

    ssd_cell_ctl_t    cell_ctl;
    logic [PIX_W-1:0] chain_pix [NC];
    logic [ACC_W-1:0] chain_acc [NC];

    function automatic logic signed [SW-1:0] clamp_lim(
        input logic signed [SW-1:0] v,
        input logic signed [SW-1:0] lim
    );
        logic signed [SW-1:0] res;
        res = v;
        if (v < 0) begin
            res = '0;
        end else if (v > lim - SW'(1)) begin
            res = lim - SW'(1);
        end
        return res;
    endfunction

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign load_fire  = s_fire && (s_command == CMD_LOAD);
    assign match_fire = s_fire && (s_command == CMD_MATCH);
    assign clear_fire = s_fire && (s_command == CMD_CLEAR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= 3'd2;
            max_disp_reg <= 6'd16;
            width_reg    <= 7'd64;
            height_reg   <= 7'd64;
            channels_reg <= 2'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RADIUS:   radius_reg   <= cfg_data[2:0];
                CFG_MAX_DISP: max_disp_reg <= cfg_data[5:0];
                CFG_WIDTH:    width_reg    <= cfg_data;
                CFG_HEIGHT:   height_reg   <= cfg_data;
                CFG_CHANNELS: channels_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == 7'd0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == 7'd0) begin
            h_eff = HW'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_reg);
        end
        r_eff  = (32'(radius_reg) > 32'(MAX_RADIUS)) ? RDW'(MAX_RADIUS) : RDW'(radius_reg);
        dm_eff = (32'(max_disp_reg) > 32'(MAX_SEARCH)) ? KW'(MAX_SEARCH) : KW'(max_disp_reg);
        nch_eff = (channels_reg == 2'd0) ? 2'd1 : channels_reg;
        x_eff = (32'(s_column) > 32'(w_eff) - 1) ? XW'(32'(w_eff) - 1) : XW'(s_column);
        y_eff = (32'(s_row) > 32'(h_eff) - 1) ? YW'(32'(h_eff) - 1) : YW'(s_row);
        d0_eff = (32'(x_eff) > 32'(dm_eff)) ? XW'(32'(x_eff) - 32'(dm_eff)) : '0;
    end

    assign waddr = AW'(32'(s_row) * MAX_WIDTH + 32'(s_column));

    always_comb begin
        e_last   = EW'(NC - 1) + EW'({r_reg, 1'b0});
        row_last = (e_reg == e_last);
        issue    = (state_reg == ST_ROW);
        yy_s   = SW'(y_reg) - SW'(r_reg) + SW'(j_reg);
        rcol_s = SW'(d0_reg) - SW'(r_reg) + SW'(e_reg);
        lcol_s = SW'(x_reg) + SW'(e_reg) - SW'(NC - 1) - SW'(r_reg);
        yy     = YW'(clamp_lim(yy_s, SW'(h_reg)));
        rcol   = XW'(clamp_lim(rcol_s, SW'(w_reg)));
        lcol   = XW'(clamp_lim(lcol_s, SW'(w_reg)));
        raddr  = AW'(32'(yy) * MAX_WIDTH + 32'(rcol));
        laddr  = AW'(32'(yy) * MAX_WIDTH + 32'(lcol));
    end

    always_ff @(posedge aclk) begin
        if (load_fire && 32'(s_column) < 32'(MAX_WIDTH) && 32'(s_row) < 32'(MAX_HEIGHT)) begin
            left_mem[waddr]  <= {s_left_ch2, s_left_ch1, s_left_ch0};
            right_mem[waddr] <= {s_right_ch2, s_right_ch1, s_right_ch0};
        end
        left_rd_reg  <= left_mem[laddr];
        right_rd_reg <= right_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rvalid_reg <= 1'b0;
            racc_reg   <= 1'b0;
        end else begin
            rvalid_reg <= issue;
            racc_reg   <= issue && (e_reg >= EW'(NC - 1));
        end
    end

    always_comb begin
        cell_ctl.shift  = rvalid_reg;
        cell_ctl.acc_en = rvalid_reg && racc_reg;
        cell_ctl.clear  = match_fire;
        cell_ctl.scan   = (state_reg == ST_SCAN);
    end

    for (genvar k = 0; k < NC; k++) begin : g_cell
        logic [PIX_W-1:0] pin;
        logic [ACC_W-1:0] ain;
        if (k == NC - 1) begin : g_end
            assign pin = right_rd_reg;
            assign ain = '0;
        end else begin : g_mid
            assign pin = chain_pix[k+1];
            assign ain = chain_acc[k+1];
        end
        ssd_cell #(.ACC_W(ACC_W)) u_cell (
            .aclk     (aclk),
            .ctl      (cell_ctl),
            .nch      (nch_reg),
            .left_pix (left_rd_reg),
            .pix_in   (pin),
            .acc_in   (ain),
            .pix_out  (chain_pix[k]),
            .acc_out  (chain_acc[k])
        );
    end

    assign out_fire   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign disp_k     = last_k_reg - bestk_reg;
    assign runmax_new = (disp_k > runmax_reg) ? disp_k : runmax_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (match_fire) state_next = ST_ROW;
            ST_ROW:   if (row_last && j_reg == JW'({r_reg, 1'b0})) state_next = ST_FLUSH;
            ST_FLUSH: state_next = ST_SCAN;
            ST_SCAN:  if (k_reg == KW'(NC - 1)) state_next = ST_DONE;
            ST_DONE:  if (out_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            runmax_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clear_fire) begin
                runmax_reg <= '0;
            end else if (out_fire) begin
                runmax_reg <= runmax_new;
            end
            if (out_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (match_fire) begin
            w_reg      <= w_eff;
            h_reg      <= h_eff;
            x_reg      <= x_eff;
            y_reg      <= y_eff;
            d0_reg     <= d0_eff;
            r_reg      <= r_eff;
            nch_reg    <= nch_eff;
            last_k_reg <= KW'(x_eff - d0_eff);
            e_reg      <= '0;
            j_reg      <= '0;
        end else if (issue) begin
            if (row_last) begin
                e_reg <= '0;
                j_reg <= j_reg + JW'(1);
            end else begin
                e_reg <= e_reg + EW'(1);
            end
        end
        if (state_reg == ST_FLUSH) begin
            k_reg <= '0;
        end else if (state_reg == ST_SCAN) begin
            k_reg <= k_reg + KW'(1);
            if (k_reg <= last_k_reg && (k_reg == '0 || chain_acc[0] < best_reg)) begin
                best_reg  <= chain_acc[0];
                bestk_reg <= k_reg;
            end
        end
        if (out_fire) begin
            m_disp_reg   <= 6'(disp_k);
            m_cost_reg   <= 26'(best_reg);
            m_runmax_reg <= 6'(runmax_new);
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_disparity         = m_disp_reg;
    assign m_best_cost         = m_cost_reg;
    assign m_largest_disparity = m_runmax_reg;

endmodule

FILE: rtl/core/ssd_cell.sv
// one candidate cell: holds a right pixel and the window cost of its candidate
module ssd_cell
    import ssd_pkg::*;
#(
    parameter int ACC_W = 26
) (
    input  logic                aclk,
    input  ssd_cell_ctl_t       ctl,
    input  logic [1:0]          nch,
    input  logic [PIX_W-1:0]    left_pix,
    input  logic [PIX_W-1:0]    pix_in,
    input  logic [ACC_W-1:0]    acc_in,
    output logic [PIX_W-1:0]    pix_out,
    output logic [ACC_W-1:0]    acc_out
);

    logic [PIX_W-1:0] pix_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [17:0]      sq0, sq1, sq2;
    logic signed [8:0] d0, d1, d2;
    logic [ACC_W-1:0] cost;

    always_comb begin
        d0 = $signed({1'b0, left_pix[7:0]})   - $signed({1'b0, pix_in[7:0]});
        d1 = $signed({1'b0, left_pix[15:8]})  - $signed({1'b0, pix_in[15:8]});
        d2 = $signed({1'b0, left_pix[23:16]}) - $signed({1'b0, pix_in[23:16]});
        sq0 = 18'(d0 * d0);
        sq1 = (nch >= 2'd2) ? 18'(d1 * d1) : 18'd0;
        sq2 = (nch >= 2'd3) ? 18'(d2 * d2) : 18'd0;
        cost = ACC_W'(sq0) + ACC_W'(sq1) + ACC_W'(sq2);
        acc_next = acc_reg;
        if (ctl.clear) begin
            acc_next = '0;
        end else if (ctl.scan) begin
            acc_next = acc_in;
        end else if (ctl.acc_en) begin
            acc_next = acc_reg + cost;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            pix_reg <= pix_in;
        end
        acc_reg <= acc_next;
    end

    assign pix_out = pix_reg;
    assign acc_out = acc_reg;

endmodule
